FILE: hdl/tcma_pkg.sv
`timescale 1ns / 1ps
// tcma_pkg: shared constants and types for the three-channel moving average.
// No dependencies.

package tcma_pkg;

    // Fixed field widths
    localparam int REG_W   = 11;   // window length register
    localparam int STAMP_W = 32;   // time stamp

    // Defaults for the top-level parameters
    localparam int WINDOW_MAX_DEF   = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam logic [REG_W-1:0] WIN_LEN_RST = REG_W'(16);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_LOAD
    } t_state;

    // Channel select for the shared divider
    typedef enum logic [1:0] {
        CH_A,
        CH_B,
        CH_C
    } t_chan;

endpackage

FILE: hdl/tcma_ring.sv
`timescale 1ns / 1ps
// tcma_ring: sample history memory, one write port, one registered read port.
// Holds all three channels side by side in one word. No dependencies.

module tcma_ring #(
    parameter  int DEPTH  = 1024,
    parameter  int DATA_W = 96,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tcma_div.sv
`timescale 1ns / 1ps
// tcma_div: shared restoring divider, signed sum by unsigned window length,
// one quotient bit per cycle, truncation toward zero. No dependencies.

module tcma_div #(
    parameter  int WINDOW_MAX   = 1024,
    parameter  int SAMPLE_WIDTH = 32,
    localparam int SUM_W        = SAMPLE_WIDTH + $clog2(WINDOW_MAX),
    localparam int LEN_W        = $clog2(WINDOW_MAX + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [SUM_W-1:0]        i_dividend,
    input  logic        [LEN_W-1:0]        i_divisor,
    output logic                           o_done,
    output logic signed [SAMPLE_WIDTH-1:0] o_quotient
);

    localparam int CNT_W = $clog2(SUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [LEN_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic             r_neg;

    logic [LEN_W:0]   rem_sh;
    logic             ge;
    logic [LEN_W:0]   rem_sub;
    logic [SUM_W-1:0] quo_signed;

    // one restoring step
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, i_divisor});
    assign rem_sub = rem_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_quo <= i_dividend[SUM_W-1] ? (-i_dividend) : i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign quo_signed = r_neg ? (-r_quo) : r_quo;
    assign o_quotient = quo_signed[SAMPLE_WIDTH-1:0];
    assign o_done     = r_done;

endmodule

FILE: hdl/three_channel_moving_average.sv
`timescale 1ns / 1ps
// three_channel_moving_average: top level, sequencer, running sums, output register.
// Depends on tcma_pkg, tcma_ring, tcma_div.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  in       | i_in_valid / o_in_ready | i_time_stamp, i_sample_a/b/c
//  out      | o_out_valid/ i_out_ready| o_time_stamp_out, o_mean_a/b/c
//  config   | i_cfg_wr_en (no wait)   | i_cfg_wr_data (window length)
//
// An item that fills no full window passes through accept and sum update only.
// An item that yields a result also passes through the single restoring divider,
// which runs SUM_W steps per channel for channels A, B and C in turn, then loads.
// o_in_ready is high only while the sequencer is idle.
// A finished result sits in the output register; the next item is accepted
// while it waits, and the sequencer stalls in its load state only if a second
// result is done before the first has been taken.
// Reset (synchronous, active low) sets the window length to 16 and empties
// the window. A config write also empties the window. No clearing pass: the
// history memory data is used only from slots written since the window was emptied.

module three_channel_moving_average #(
    parameter int WINDOW_MAX   = tcma_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = tcma_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config
    input  logic                               i_cfg_wr_en,
    input  logic [tcma_pkg::REG_W-1:0]         i_cfg_wr_data,
    // input items
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [tcma_pkg::STAMP_W-1:0] i_time_stamp,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_a,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_b,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample_c,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [tcma_pkg::STAMP_W-1:0] o_time_stamp_out,
    output logic signed [SAMPLE_WIDTH-1:0]     o_mean_a,
    output logic signed [SAMPLE_WIDTH-1:0]     o_mean_b,
    output logic signed [SAMPLE_WIDTH-1:0]     o_mean_c
);

    localparam int ADDR_W = $clog2(WINDOW_MAX);
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SAMPLE_WIDTH + $clog2(WINDOW_MAX);
    localparam int SW     = SAMPLE_WIDTH;
    localparam int HIST_W = 3 * SAMPLE_WIDTH;

    // ---------------- state ----------------
    tcma_pkg::t_state r_state, n_state;
    tcma_pkg::t_chan  r_ch;

    logic [tcma_pkg::REG_W-1:0]    r_win_len;
    logic [ADDR_W-1:0]             r_slot;      // next ring position
    logic [ADDR_W-1:0]             r_cur_slot;  // position of item in flight
    logic [LEN_W-1:0]              r_fill;
    logic signed [SUM_W-1:0]       r_sum_a, r_sum_b, r_sum_c;

    // item in flight
    logic signed [tcma_pkg::STAMP_W-1:0] r_ts;
    logic signed [SW-1:0]          r_smp_a, r_smp_b, r_smp_c;
    logic signed [SW-1:0]          r_q_a, r_q_b, r_q_c;

    // output register
    logic                          r_out_valid;
    logic signed [tcma_pkg::STAMP_W-1:0] r_out_ts;
    logic signed [SW-1:0]          r_out_a, r_out_b, r_out_c;

    // ---------------- window length ----------------
    // zero acts as one, anything above WINDOW_MAX saturates
    logic [31:0]      len32;
    logic [LEN_W-1:0] act_len;

    always_comb begin
        if (r_win_len == '0) begin
            len32 = 32'd1;
        end else if (32'(r_win_len) > 32'(WINDOW_MAX)) begin
            len32 = 32'(WINDOW_MAX);
        end else begin
            len32 = 32'(r_win_len);
        end
    end
    assign act_len = len32[LEN_W-1:0];

    // ---------------- ring position ----------------
    logic [ADDR_W-1:0] slot_use;
    logic [LEN_W-1:0]  slot_inc;
    logic [ADDR_W-1:0] slot_next;

    assign slot_use  = (LEN_W'(r_slot) >= act_len) ? '0 : r_slot;
    assign slot_inc  = LEN_W'(r_cur_slot) + LEN_W'(1);
    assign slot_next = (slot_inc >= act_len) ? '0 : slot_inc[ADDR_W-1:0];

    // ---------------- history memory ----------------
    logic              accept;
    logic              ring_we;
    logic [HIST_W-1:0] ring_rdata;

    assign accept = i_in_valid && o_in_ready;

    tcma_ring #(
        .DEPTH  (WINDOW_MAX),
        .DATA_W (HIST_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_cur_slot),
        .i_wdata ({r_smp_c, r_smp_b, r_smp_a}),
        .i_re    (accept),
        .i_raddr (slot_use),
        .o_rdata (ring_rdata)
    );

    // ---------------- sum update ----------------
    // once the window is full the oldest sample leaves as the new one enters
    logic                  full;
    logic                  emit;
    logic signed [SW-1:0]  old_a, old_b, old_c;
    logic signed [SW:0]    dlt_a, dlt_b, dlt_c;

    assign full  = (r_fill >= act_len);
    assign emit  = full || ((r_fill + LEN_W'(1)) >= act_len);
    assign old_a = ring_rdata[SW-1:0];
    assign old_b = ring_rdata[2*SW-1:SW];
    assign old_c = ring_rdata[3*SW-1:2*SW];
    assign dlt_a = full ? ((SW+1)'(r_smp_a) - (SW+1)'(old_a)) : (SW+1)'(r_smp_a);
    assign dlt_b = full ? ((SW+1)'(r_smp_b) - (SW+1)'(old_b)) : (SW+1)'(r_smp_b);
    assign dlt_c = full ? ((SW+1)'(r_smp_c) - (SW+1)'(old_c)) : (SW+1)'(r_smp_c);

    // ---------------- shared divider ----------------
    logic                    div_start;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_dividend;
    logic signed [SW-1:0]    div_quo;

    always_comb begin
        case (r_ch)
            tcma_pkg::CH_A: div_dividend = r_sum_a;
            tcma_pkg::CH_B: div_dividend = r_sum_b;
            tcma_pkg::CH_C: div_dividend = r_sum_c;
            default:        div_dividend = r_sum_a;
        endcase
    end

    tcma_div #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (act_len),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // ---------------- sequencer ----------------
    logic out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcma_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        ring_we    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            tcma_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = tcma_pkg::S_UPD;
                end
            end
            tcma_pkg::S_UPD: begin
                ring_we = 1'b1;
                n_state = emit ? tcma_pkg::S_DIV_GO : tcma_pkg::S_IDLE;
            end
            tcma_pkg::S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = tcma_pkg::S_DIV_WAIT;
            end
            tcma_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_ch == tcma_pkg::CH_C) ? tcma_pkg::S_LOAD
                                                       : tcma_pkg::S_DIV_GO;
                end
            end
            tcma_pkg::S_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = tcma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcma_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= tcma_pkg::WIN_LEN_RST;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_sum_c     <= '0;
            r_ch        <= tcma_pkg::CH_A;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                // new length: window refills from empty
                r_win_len <= i_cfg_wr_data;
                r_slot    <= '0;
                r_fill    <= '0;
                r_sum_a   <= '0;
                r_sum_b   <= '0;
                r_sum_c   <= '0;
            end else if (r_state == tcma_pkg::S_UPD) begin
                r_sum_a <= r_sum_a + SUM_W'(dlt_a);
                r_sum_b <= r_sum_b + SUM_W'(dlt_b);
                r_sum_c <= r_sum_c + SUM_W'(dlt_c);
                r_slot  <= slot_next;
                if (!full) begin
                    r_fill <= r_fill + LEN_W'(1);
                end
            end

            if (r_state == tcma_pkg::S_UPD) begin
                r_ch <= tcma_pkg::CH_A;
            end else if (div_done) begin
                case (r_ch)
                    tcma_pkg::CH_A: r_ch <= tcma_pkg::CH_B;
                    tcma_pkg::CH_B: r_ch <= tcma_pkg::CH_C;
                    default:        r_ch <= tcma_pkg::CH_A;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ts       <= i_time_stamp;
            r_smp_a    <= i_sample_a;
            r_smp_b    <= i_sample_b;
            r_smp_c    <= i_sample_c;
            r_cur_slot <= slot_use;
        end
        if (div_done) begin
            case (r_ch)
                tcma_pkg::CH_A: r_q_a <= div_quo;
                tcma_pkg::CH_B: r_q_b <= div_quo;
                default:        r_q_c <= div_quo;
            endcase
        end
        if (out_load) begin
            r_out_ts <= r_ts;
            r_out_a  <= r_q_a;
            r_out_b  <= r_q_b;
            r_out_c  <= r_q_c;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_time_stamp_out = r_out_ts;
    assign o_mean_a         = r_out_a;
    assign o_mean_b         = r_out_b;
    assign o_mean_c         = r_out_c;

endmodule

FILE: hdl/tcma_checker.sv
`timescale 1ns / 1ps
// tcma_checker: port-level assertions for the moving average, bound to the top.
// Depends on tcma_pkg and three_channel_moving_average.

module tcma_checker #(
    parameter int SAMPLE_WIDTH = tcma_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [tcma_pkg::STAMP_W-1:0]  o_time_stamp_out,
    input logic [SAMPLE_WIDTH-1:0]       o_mean_a
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_time_stamp_out) && $stable(o_mean_a))
        else $error("stalled result dropped or changed");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    // a new result only appears out of a busy sequencer
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while idle");

endmodule

bind three_channel_moving_average tcma_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_tcma_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_time_stamp_out (o_time_stamp_out),
    .o_mean_a         (o_mean_a)
);
